@@ rtl/core/imu_frame_sync_bcd_decoder_unit_macros.svh @@
// Assertion helpers for the RTL. Every check is clocked on clk_i
// and is disabled while rst_ni is low.
`ifndef IMU_FRAME_SYNC_BCD_DECODER_UNIT_MACROS_SVH
`define IMU_FRAME_SYNC_BCD_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define IMUFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IMUFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/imufs_pkg.sv @@
package imufs_pkg;

  localparam int FrameLen     = 32;
  localparam int CmdPos       = 3;
  localparam int FirstField   = 4;
  localparam int NumFields    = 9;
  localparam int BytesPerFld  = 3;
  localparam int PayloadBytes = NumFields * BytesPerFld;
  localparam int FieldW       = 19;
  localparam int MagW         = 18;
  localparam int FillW        = $clog2(FrameLen + 1);
  localparam int IdxW         = $clog2(FrameLen);
  localparam int FldIdxW      = $clog2(NumFields);
  localparam int FifoDepth    = 2;
  localparam int FifoPtrW     = $clog2(FifoDepth);
  localparam int FifoCntW     = $clog2(FifoDepth + 1);
  localparam int CfgIdxW      = 8;

  typedef logic [7:0] byte_t;

  localparam logic [CfgIdxW-1:0] CFG_HEADER   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DATA_CMD = CfgIdxW'(1);
  localparam byte_t HeaderRst  = 8'h68;
  localparam byte_t DataCmdRst = 8'h84;

  typedef logic [PayloadBytes-1:0][7:0]             payload_t;
  typedef logic [NumFields-1:0][BytesPerFld*8-1:0]  triples_t;
  typedef logic signed [FieldW-1:0]                 field_t;

  // Frame handed from the front end to the queue.
  typedef struct packed {
    logic     valid;
    payload_t payload;
  } push_t;

  // Oldest queued frame as seen by the decoder.
  typedef struct packed {
    logic     valid;
    payload_t payload;
  } head_t;

  // Sign nibble, then five digits weighted as is (no range check).
  function automatic field_t decode_bcd(input logic [BytesPerFld*8-1:0] t);
    logic [MagW-1:0] mag;
    logic [3:0]      sgn;
    sgn = t[7:4];
    mag = MagW'(t[3:0])   * MagW'(10000)
        + MagW'(t[15:12]) * MagW'(1000)
        + MagW'(t[11:8])  * MagW'(100)
        + MagW'(t[23:20]) * MagW'(10)
        + MagW'(t[19:16]);
    decode_bcd = (sgn != 4'd0) ? field_t'(-$signed({1'b0, mag})) : field_t'({1'b0, mag});
  endfunction

endpackage

@@ rtl/core/imufs_front.sv @@
`include "imu_frame_sync_bcd_decoder_unit_macros.svh"

module imufs_front
  import imufs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  byte_t rx_byte_i,
  input  byte_t header_i,
  input  byte_t data_cmd_i,
  input  logic  full_i,
  output push_t push_o
);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SUM,
    ST_CHECK,
    ST_PUSH
  } fr_state_e;

  fr_state_e                    state_q, state_d;
  logic [FrameLen-1:0][7:0]     window_q, window_d;
  logic [FillW-1:0]             fill_q, fill_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  byte_t                        sum_q, sum_d;
  logic                         accept;
  logic                         frame_ok;

  assign in_stall_o = (state_q != ST_FILL);
  assign accept     = in_valid_i && (state_q == ST_FILL);
  assign frame_ok   = (window_q[0] == header_i) && (sum_q == window_q[FrameLen-1]);

  assign push_o.valid   = (state_q == ST_PUSH) && !full_i;
  assign push_o.payload = window_q[FrameLen-2:FirstField];

  always_comb begin
    state_d  = state_q;
    window_d = window_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    case (state_q)
      ST_FILL: begin
        if (accept) begin
          // shift in at the top, oldest byte falls out of slot 0
          window_d = {rx_byte_i, window_q[FrameLen-1:1]};
          fill_d   = fill_q + FillW'(1);
          if (fill_q == FillW'(FrameLen - 1)) begin
            state_d = ST_SUM;
            idx_d   = IdxW'(1);
            sum_d   = '0;
          end
        end
      end
      ST_SUM: begin
        sum_d = sum_q + window_q[idx_q];
        idx_d = idx_q + IdxW'(1);
        if (idx_q == IdxW'(FrameLen - 2)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!frame_ok) begin
          // drop the oldest byte: the next transfer shifts it out
          fill_d  = FillW'(FrameLen - 1);
          state_d = ST_FILL;
        end else begin
          fill_d  = '0;
          state_d = (window_q[CmdPos] == data_cmd_i) ? ST_PUSH : ST_FILL;
        end
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      window_q <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
    end else begin
      state_q  <= state_d;
      window_q <= window_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
    end
  end

  `IMUFS_ASSERT_NXT(a_full_starts_sum, accept && (fill_q == FillW'(FrameLen - 1)),
                    state_q == ST_SUM, "full window did not start the checksum")
  `IMUFS_ASSERT_IMP(a_fill_bounded, state_q == ST_FILL, fill_q < FillW'(FrameLen),
                    "window count out of range while filling")
  `IMUFS_ASSERT_IMP(a_no_push_when_full, push_o.valid, !full_i,
                    "frame pushed into a full queue")
  `IMUFS_ASSERT_NXT(a_sum_to_check, (state_q == ST_SUM) && (idx_q == IdxW'(FrameLen - 2)),
                    state_q == ST_CHECK, "checksum pass did not end in the check")

endmodule

@@ rtl/core/imufs_fifo.sv @@
module imufs_fifo
  import imufs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output head_t head_o,
  input  logic  pop_i
);

  payload_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o         = (cnt_q == FifoCntW'(FifoDepth));
  assign head_o.valid   = (cnt_q != '0);
  assign head_o.payload = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.payload;
    end
  end

endmodule

@@ rtl/core/imufs_decode.sv @@
module imufs_decode
  import imufs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  head_t  head_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output field_t fields_o [NumFields]
);

  typedef enum logic [1:0] {
    DC_IDLE,
    DC_RUN,
    DC_LOAD
  } dc_state_e;

  dc_state_e            state_q, state_d;
  triples_t             frame_q, frame_d;
  logic [FldIdxW-1:0]   cnt_q, cnt_d;
  field_t               work_q [NumFields];
  field_t               work_d [NumFields];
  field_t               out_q  [NumFields];
  field_t               out_d  [NumFields];
  logic                 out_valid_q, out_valid_d;
  logic                 load;

  assign pop_o       = (state_q == DC_IDLE) && head_i.valid;
  assign load        = (state_q == DC_LOAD) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign fields_o    = out_q;

  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    cnt_d       = cnt_q;
    work_d      = work_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      DC_IDLE: begin
        if (head_i.valid) begin
          frame_d = triples_t'(head_i.payload);
          cnt_d   = '0;
          state_d = DC_RUN;
        end
      end
      DC_RUN: begin
        // one field per cycle
        work_d[cnt_q] = decode_bcd(frame_q[cnt_q]);
        cnt_d         = cnt_q + FldIdxW'(1);
        if (cnt_q == FldIdxW'(NumFields - 1)) begin
          state_d = DC_LOAD;
        end
      end
      DC_LOAD: begin
        // hold until the output register is free or being drained
        if (load) begin
          out_d       = work_q;
          out_valid_d = 1'b1;
          state_d     = DC_IDLE;
        end
      end
      default: begin
        state_d = DC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DC_IDLE;
      frame_q     <= '0;
      cnt_q       <= '0;
      work_q      <= '{default: '0};
      out_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      cnt_q       <= cnt_d;
      work_q      <= work_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/imu_frame_sync_bcd_decoder_unit.sv @@
// Takes one byte per cycle while filling the 32-byte window; the byte that fills it
// stalls input through a serial checksum over bytes 1 to 30 and the compare, then
// through the push if a data frame is queued, and longer while the queue is full.
// With the back end free, a data frame goes from its last byte through the front end,
// the queue and the decoder into the output register.
// Asynchronous active-low reset empties window, queue and output; registers return to 0x68/0x84.
module imu_frame_sync_bcd_decoder_unit
  import imufs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  byte_t               cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  byte_t               rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output field_t              angle_x_o,
  output field_t              angle_y_o,
  output field_t              angle_z_o,
  output field_t              accel_x_o,
  output field_t              accel_y_o,
  output field_t              accel_z_o,
  output field_t              rate_x_o,
  output field_t              rate_y_o,
  output field_t              rate_z_o
);

  byte_t  header_q, header_d;
  byte_t  data_cmd_q, data_cmd_d;
  push_t  push;
  head_t  head;
  logic   full;
  logic   pop;
  field_t fields [NumFields];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    header_d   = header_q;
    data_cmd_d = data_cmd_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEADER:   header_d   = cfg_data_i;
        CFG_DATA_CMD: data_cmd_d = cfg_data_i;
        default: begin
          // unknown register: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= HeaderRst;
      data_cmd_q <= DataCmdRst;
    end else begin
      header_q   <= header_d;
      data_cmd_q <= data_cmd_d;
    end
  end

  imufs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .header_i   (header_q),
    .data_cmd_i (data_cmd_q),
    .full_i     (full),
    .push_o     (push)
  );

  imufs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  imufs_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .fields_o    (fields)
  );

  assign angle_x_o = fields[0];
  assign angle_y_o = fields[1];
  assign angle_z_o = fields[2];
  assign accel_x_o = fields[3];
  assign accel_y_o = fields[4];
  assign accel_z_o = fields[5];
  assign rate_x_o  = fields[6];
  assign rate_y_o  = fields[7];
  assign rate_z_o  = fields[8];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import imufs_pkg::*;

  localparam int SettleCycles = 64;
  localparam int HoldCycles   = 700;
  localparam int IdlePct      = 28;
  localparam int DrainLimit   = 20000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = '1;

  typedef logic signed [NumFields-1:0][FieldW-1:0] imu_sample_t;

  class frame_scoreboard;
    byte_t       header_val;
    byte_t       data_cmd_val;
    byte_t       win [FrameLen];
    int          fill;
    imu_sample_t pending_samples [$];
    string       field_name [NumFields];
    int          errors;
    int          frames_taken;
    int          data_frames;
    int          slips;
    int          compared;

    function new();
      header_val   = HeaderRst;
      data_cmd_val = DataCmdRst;
      fill         = 0;
      errors       = 0;
      frames_taken = 0;
      data_frames  = 0;
      slips        = 0;
      compared     = 0;
      field_name   = '{"angle_x", "angle_y", "angle_z", "accel_x", "accel_y", "accel_z",
                       "rate_x", "rate_y", "rate_z"};
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, byte_t val);
      if (idx == CFG_HEADER) begin
        header_val = val;
      end else if (idx == CFG_DATA_CMD) begin
        data_cmd_val = val;
      end
    endfunction

    // Sign nibble, then five digits taken at face value even above nine.
    function logic [FieldW-1:0] bcd_value(byte_t hi, byte_t mid, byte_t lo);
      int unsigned mag;
      mag = hi[3:0] * 10000 + mid[7:4] * 1000 + mid[3:0] * 100 + lo[7:4] * 10 + lo[3:0];
      if (hi[7:4] != 4'd0) begin
        return FieldW'(32'd0 - mag);
      end
      return FieldW'(mag);
    endfunction

    function void note_rx_byte(byte_t b);
      logic [7:0]  csum;
      imu_sample_t s;
      int          p;
      if (fill >= FrameLen) fill = FrameLen - 1;
      win[fill] = b;
      fill++;
      if (fill < FrameLen) return;
      csum = '0;
      for (int i = 1; i < FrameLen - 1; i++) csum += win[i];
      if (win[0] != header_val || csum != win[FrameLen-1]) begin
        // slide by one byte and keep hunting for a frame start
        for (int i = 0; i < FrameLen - 1; i++) win[i] = win[i+1];
        fill = FrameLen - 1;
        slips++;
        return;
      end
      fill = 0;
      frames_taken++;
      if (win[CmdPos] != data_cmd_val) return;
      for (int k = 0; k < NumFields; k++) begin
        p = FirstField + BytesPerFld * k;
        s[k] = bcd_value(win[p], win[p+1], win[p+2]);
      end
      pending_samples.push_back(s);
      data_frames++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_result(imu_sample_t got);
      imu_sample_t want;
      if (pending_samples.size() == 0) begin
        report($sformatf("result with none pending, angle_x %0d", $signed(got[0])));
        return;
      end
      want = pending_samples.pop_front();
      compared++;
      for (int k = 0; k < NumFields; k++) begin
        if (got[k] !== want[k]) begin
          report($sformatf("result %0d %s: got %0d, want %0d", compared, field_name[k],
                           $signed(got[k]), $signed(want[k])));
        end
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  byte_t              cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  byte_t              rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  field_t             angle_x_o, angle_y_o, angle_z_o;
  field_t             accel_x_o, accel_y_o, accel_z_o;
  field_t             rate_x_o, rate_y_o, rate_z_o;
  imu_sample_t        seen;

  frame_scoreboard sb = new();
  byte_t           frame_buf [FrameLen];
  bit              idle_on = 1'b1;
  int              hold_left = 0;
  int              bytes_sent = 0;
  int              settings_seen = 1;

  imu_frame_sync_bcd_decoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_x_o   (angle_x_o),
    .angle_y_o   (angle_y_o),
    .angle_z_o   (angle_z_o),
    .accel_x_o   (accel_x_o),
    .accel_y_o   (accel_y_o),
    .accel_z_o   (accel_z_o),
    .rate_x_o    (rate_x_o),
    .rate_y_o    (rate_y_o),
    .rate_z_o    (rate_z_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  assign seen = {rate_z_o, rate_y_o, rate_x_o, accel_z_o, accel_y_o, accel_x_o,
                 angle_z_o, angle_y_o, angle_x_o};

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(seen);
  end

  // Result side: a long hold when requested, random stalls otherwise.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 99) < 80) return 4'($urandom_range(0, 9));
    return 4'($urandom_range(10, 15));
  endfunction

  function automatic void seal_frame();
    byte_t csum;
    csum = '0;
    for (int i = 1; i < FrameLen - 1; i++) csum += frame_buf[i];
    frame_buf[FrameLen-1] = csum;
  endfunction

  function automatic void build_frame(byte_t hdr, byte_t cmd);
    int         p;
    logic [3:0] sgn;
    frame_buf[0]      = hdr;
    frame_buf[1]      = 8'($urandom);
    frame_buf[2]      = 8'($urandom);
    frame_buf[CmdPos] = cmd;
    for (int k = 0; k < NumFields; k++) begin
      p   = FirstField + BytesPerFld * k;
      sgn = $urandom_range(0, 1) ? 4'($urandom_range(1, 15)) : 4'd0;
      frame_buf[p]   = {sgn, rand_digit()};
      frame_buf[p+1] = {rand_digit(), rand_digit()};
      frame_buf[p+2] = {rand_digit(), rand_digit()};
    end
    seal_frame();
  endfunction

  function automatic void put_field(int k, byte_t b0, byte_t b1, byte_t b2);
    int p;
    p = FirstField + BytesPerFld * k;
    frame_buf[p]   = b0;
    frame_buf[p+1] = b1;
    frame_buf[p+2] = b2;
  endfunction

  task automatic send_byte(input byte_t b);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < FrameLen; i++) send_byte(frame_buf[i]);
  endtask

  // Always waits for a clock edge first, so valid is never dropped and raised in the same step.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input byte_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic reconfigure(input byte_t hdr, input byte_t cmd, input bit poke_spare);
    wait_results_drained();
    // let a silently consumed frame finish its check before touching registers
    repeat (SettleCycles) @(posedge clk_i);
    put_reg(CFG_HEADER, hdr);
    put_reg(CFG_DATA_CMD, cmd);
    if (poke_spare) begin
      put_reg(CFG_SPARE_LO, 8'($urandom));
      put_reg(CFG_SPARE_HI, 8'($urandom));
    end
    cfg_valid_i <= 1'b0;
    settings_seen++;
  endtask

  task automatic random_traffic(input int n_bytes, input int min_results);
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes || sb.data_frames < min_results) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) wait_results_drained();
      if (pick < 93) begin
        build_frame(sb.header_val, sb.data_cmd_val);
        if (pick >= 70 && pick < 78) begin
          frame_buf[CmdPos] ^= 8'($urandom_range(1, 255));
          seal_frame();
        end else if (pick >= 78 && pick < 86) begin
          frame_buf[$urandom_range(1, FrameLen - 1)] ^= 8'($urandom_range(1, 255));
        end else if (pick >= 86) begin
          frame_buf[0] ^= 8'($urandom_range(1, 255));
          seal_frame();
        end
        send_frame();
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    int waited;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, negative zero, every sign nibble class, digits above nine.
    build_frame(HeaderRst, DataCmdRst);
    put_field(0, 8'h09, 8'h99, 8'h99);
    put_field(1, 8'hFF, 8'hFF, 8'hFF);
    put_field(2, 8'h0F, 8'hFF, 8'hFF);
    put_field(3, 8'h10, 8'h00, 8'h00);
    put_field(4, 8'h00, 8'h00, 8'h00);
    put_field(5, 8'h81, 8'h23, 8'h45);
    put_field(6, 8'h1A, 8'hB0, 8'hC7);
    put_field(7, 8'h70, 8'h00, 8'h01);
    put_field(8, 8'h00, 8'h00, 8'h01);
    seal_frame();
    send_frame();
    // valid frame with another command: consumed, no result
    build_frame(HeaderRst, DataCmdRst ^ 8'h01);
    send_frame();
    build_frame(HeaderRst, DataCmdRst);
    frame_buf[FrameLen-1] ^= 8'h80;
    send_frame();
    build_frame(HeaderRst ^ 8'h01, DataCmdRst);
    send_frame();
    build_frame(HeaderRst, DataCmdRst);
    send_frame();

    random_traffic(200, 0);

    // Back up the result path until the input stalls, then drain.
    wait_results_drained();
    hold_left = HoldCycles;
    repeat (6) begin
      build_frame(sb.header_val, sb.data_cmd_val);
      send_frame();
    end
    wait_results_drained();

    reconfigure(8'h00, 8'hFF, 1'b0);
    random_traffic(200, 0);
    reconfigure(8'hFF, 8'h00, 1'b0);
    idle_on = 1'b0;
    random_traffic(180, 0);
    idle_on = 1'b1;
    reconfigure(8'($urandom), 8'($urandom), 1'b1);
    random_traffic(170, 0);
    reconfigure(HeaderRst, DataCmdRst, 1'b1);
    random_traffic(170, 0);

    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.pending_samples.size() != 0 && waited < DrainLimit);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending_samples.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending_samples.size()));
    end

    $display("Sent %0d bytes: %0d frames consumed, %0d data frames, %0d window slips",
             bytes_sent, sb.frames_taken, sb.data_frames, sb.slips);
    $display("Compared %0d results over %0d register settings, %0d mismatches",
             sb.compared, settings_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", sb.pending_samples.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/imufs_pkg.sv
rtl/core/imufs_front.sv
rtl/core/imufs_fifo.sv
rtl/core/imufs_decode.sv
rtl/core/imu_frame_sync_bcd_decoder_unit.sv
verif/tb.sv
